@@ rtl/epv_pkg.sv @@
// Shared types and constants for the encoder position and velocity block.
// Used by the front, divider, back and top modules under rtl; depends on nothing.
package epv_pkg;

  localparam int COUNT_W   = 32;
  localparam int QUARTER_W = 30;
  localparam int POS_W     = 48;
  localparam int CPT_W     = 16;
  localparam int TURN_W    = 16;
  localparam int DATA_W    = 32;
  localparam int ADDR_W    = 4;

  localparam logic [1:0] REG_POSITION_SCALE  = 2'd0;
  localparam logic [1:0] REG_INV_WINDOW_TIME = 2'd1;
  localparam logic [1:0] REG_COUNTS_PER_TURN = 2'd2;

  localparam logic signed [31:0] SCALE_RESET = 32'sd16777216;
  localparam logic [31:0]        IVT_RESET   = 32'd65536;
  localparam logic [15:0]        CPT_RESET   = 16'd1024;

  localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
  localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};
  localparam logic [15:0]             TURN_MAX = 16'h7FFF;
  localparam logic [15:0]             TURN_MIN = 16'h8000;

  typedef struct packed {
    logic signed [COUNT_W-1:0] count;
    logic                      neg;
    logic [QUARTER_W-1:0]      quarter;
    logic [15:0]               low;
  } epv_item_t;

  typedef struct packed {
    logic signed [31:0] position_scale;
    logic [31:0]        inv_window_time;
    logic [CPT_W-1:0]   counts_per_turn;
  } epv_cfg_t;

  typedef struct packed {
    logic busy;
    logic pop;
  } epv_stat_t;

endpackage

@@ rtl/epv_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Stands alone; no package needed.
module epv_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/epv_queue.sv @@
// Short FIFO between the classify front and the compute back.
// Stands alone; width is set by the instantiating module.
module epv_queue #(
  parameter int WIDTH = 79,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output logic [WIDTH-1:0] head_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    fill;

  assign full       = (fill == CW'(DEPTH));
  assign head_valid = (fill != '0);
  assign head_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

@@ rtl/epv_front.sv @@
// Input side: takes count beats, splits sign and magnitude, queues the item.
// Depends on epv_pkg and epv_queue.
module epv_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            count_valid,
  output logic                            count_stall,
  input  logic signed [epv_pkg::COUNT_W-1:0] encoder_count,
  output logic                            head_valid,
  output epv_pkg::epv_item_t              head,
  input  logic                            pop
);
  import epv_pkg::*;

  logic [COUNT_W-1:0] mag;
  epv_item_t          item;
  logic               full;
  logic               push;

  assign mag = encoder_count[COUNT_W-1] ? (~encoder_count + 32'd1) : encoder_count;

  always_comb begin
    item.count   = encoder_count;
    item.neg     = encoder_count[COUNT_W-1];
    item.quarter = mag[COUNT_W-1:2];
    item.low     = encoder_count[15:0];
  end

  assign push        = count_valid && !full;
  assign count_stall = full;

  epv_queue #(
    .WIDTH ($bits(epv_item_t)),
    .DEPTH (2)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (item),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_data  (head)
  );

endmodule

@@ rtl/epv_div.sv @@
// Restoring divider, one quotient bit per cycle, for turn index and count in turn.
// Depends on epv_pkg.
module epv_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [epv_pkg::QUARTER_W-1:0]     dividend,
  input  logic [epv_pkg::CPT_W-1:0]         divisor,
  output logic                              busy,
  output logic [epv_pkg::QUARTER_W-1:0]     quotient,
  output logic [epv_pkg::CPT_W-1:0]         remainder
);
  import epv_pkg::*;

  localparam int STEPS = QUARTER_W;
  localparam int CNT_W = $clog2(STEPS + 1);

  logic [QUARTER_W-1:0] quo;
  logic [CPT_W-1:0]     rem;
  logic [CPT_W-1:0]     dsr;
  logic [CNT_W-1:0]     cnt;
  logic [CPT_W:0]       shifted;
  logic [CPT_W:0]       trial;

  assign shifted   = {rem, quo[QUARTER_W-1]};
  assign trial     = shifted - {1'b0, dsr};
  assign busy      = (cnt != '0);
  assign quotient  = quo;
  assign remainder = rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CNT_W'(STEPS);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dsr <= (divisor == '0) ? CPT_W'(1) : divisor;
    end else if (busy) begin
      if (!trial[CPT_W]) begin
        rem <= trial[CPT_W-1:0];
        quo <= {quo[QUARTER_W-2:0], 1'b1};
      end else begin
        rem <= shifted[CPT_W-1:0];
        quo <= {quo[QUARTER_W-2:0], 1'b0};
      end
    end
  end

endmodule

@@ rtl/epv_back.sv @@
// Compute side: shared multiplier sequencer, position history ring, divider, result register.
// Depends on epv_pkg, epv_ram and epv_div.
module epv_back #(
  parameter int WINDOW_LEN = 8
) (
  input  logic                               clk,
  input  logic                               rst,
  input  epv_pkg::epv_cfg_t                  cfg,
  input  logic                               head_valid,
  input  epv_pkg::epv_item_t                 head,
  output logic                               pop,
  output epv_pkg::epv_stat_t                 stat,
  output logic                               result_valid,
  input  logic                               result_stall,
  output logic signed [epv_pkg::POS_W-1:0]   position,
  output logic signed [epv_pkg::POS_W-1:0]   velocity,
  output logic signed [epv_pkg::TURN_W-1:0]  turn_index,
  output logic [epv_pkg::CPT_W-1:0]          count_in_turn,
  output logic [15:0]                        count_low
);
  import epv_pkg::*;

  localparam int PTR_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam logic [49:0] VEL_LIM = 50'h8000_0000_0000;

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_MPOS = 8'b0000_0010,
    ST_POS  = 8'b0000_0100,
    ST_DIFF = 8'b0000_1000,
    ST_MLO  = 8'b0001_0000,
    ST_MHI  = 8'b0010_0000,
    ST_VEL  = 8'b0100_0000,
    ST_DONE = 8'b1000_0000
  } state_t;

  state_t                    state;
  state_t                    state_next;
  epv_item_t                 cur;
  logic signed [32:0]        mul_a;
  logic signed [32:0]        mul_b;
  logic signed [65:0]        mul_p;
  logic [63:0]               prod;
  logic [63:0]               lo_r;
  logic signed [63:0]        pos_sum;
  logic [8:0]                pos_top;
  logic signed [POS_W-1:0]   pos_sat;
  logic signed [POS_W-1:0]   pos_r;
  logic signed [POS_W-1:0]   old_r;
  logic [POS_W:0]            diff;
  logic                      vneg;
  logic [POS_W:0]            vmag;
  logic [49:0]               vsum;
  logic                      vbig;
  logic                      vlim;
  logic [POS_W-1:0]          vel_mag;
  logic signed [POS_W-1:0]   vel_final;
  logic [PTR_W-1:0]          ptr;
  logic                      wrapped;
  logic [POS_W-1:0]          rdata;
  logic                      hist_we;
  logic                      div_busy;
  logic [QUARTER_W-1:0]      quo;
  logic [CPT_W-1:0]          rem;
  logic                      inexact;
  logic [QUARTER_W:0]        qn;
  logic [TURN_W-1:0]         turn_final;
  logic                      load;

  assign pop       = (state == ST_IDLE) && head_valid;
  assign stat.busy = (state != ST_IDLE);
  assign stat.pop  = pop;
  assign hist_we   = (state == ST_DIFF);
  assign load      = (state == ST_DONE) && !div_busy && (!result_valid || !result_stall);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_MPOS: begin
        mul_a = {cur.count[COUNT_W-1], cur.count};
        mul_b = {cfg.position_scale[31], cfg.position_scale};
      end
      ST_MLO: begin
        mul_a = {1'b0, vmag[31:0]};
        mul_b = {1'b0, cfg.inv_window_time};
      end
      ST_MHI: begin
        mul_a = {16'd0, vmag[POS_W:32]};
        mul_b = {1'b0, cfg.inv_window_time};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Round to nearest with ties up, then clamp to 48 bits.
  assign pos_sum = $signed(prod) + 64'sd128;
  assign pos_top = pos_sum[63:55];

  always_comb begin
    if ((pos_top == '0) || (pos_top == '1)) begin
      pos_sat = pos_sum[55:8];
    end else if (pos_sum[63]) begin
      pos_sat = POS_MIN;
    end else begin
      pos_sat = POS_MAX;
    end
  end

  assign diff = {pos_r[POS_W-1], pos_r} - {old_r[POS_W-1], old_r};

  assign vlim    = vbig || (vsum > VEL_LIM);
  assign vel_mag = vlim ? POS_MIN : vsum[POS_W-1:0];

  always_comb begin
    if (vneg) begin
      vel_final = ~vel_mag + 48'd1;
    end else if (vlim || vsum[POS_W-1]) begin
      vel_final = POS_MAX;
    end else begin
      vel_final = vsum[POS_W-1:0];
    end
  end

  assign inexact = (rem != '0) || (cur.count[1:0] != 2'b00);
  assign qn      = {1'b0, quo} + {{QUARTER_W{1'b0}}, inexact};

  always_comb begin
    if (!cur.neg) begin
      turn_final = (quo > QUARTER_W'(TURN_MAX)) ? TURN_MAX : quo[TURN_W-1:0];
    end else if (qn > (QUARTER_W + 1)'(TURN_MIN)) begin
      turn_final = TURN_MIN;
    end else begin
      turn_final = ~qn[TURN_W-1:0] + 16'd1;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (head_valid) begin
        state_next = ST_MPOS;
      end
      ST_MPOS: state_next = ST_POS;
      ST_POS:  state_next = ST_DIFF;
      ST_DIFF: state_next = ST_MLO;
      ST_MLO:  state_next = ST_MHI;
      ST_MHI:  state_next = ST_VEL;
      ST_VEL:  state_next = ST_DONE;
      ST_DONE: if (load) begin
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      ptr          <= '0;
      wrapped      <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (hist_we) begin
        if (ptr == PTR_W'(WINDOW_LEN - 1)) begin
          ptr     <= '0;
          wrapped <= 1'b1;
        end else begin
          ptr <= ptr + 1'b1;
        end
      end
      if (load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
    prod <= mul_p[63:0];
    if (state == ST_POS) begin
      pos_r <= pos_sat;
      old_r <= wrapped ? rdata : '0;
    end
    if (state == ST_DIFF) begin
      vneg <= diff[POS_W];
      vmag <= diff[POS_W] ? (~diff + 49'd1) : diff;
    end
    if (state == ST_MHI) begin
      lo_r <= prod;
    end
    if (state == ST_VEL) begin
      vbig <= (prod[63:31] != '0);
      vsum <= {3'b000, prod[30:0], 16'd0} + {2'b00, lo_r[63:16]} + {49'd0, lo_r[15]};
    end
    if (load) begin
      position      <= pos_r;
      velocity      <= vel_final;
      turn_index    <= turn_final;
      count_in_turn <= rem;
      count_low     <= cur.low;
    end
  end

  epv_ram #(
    .WIDTH (POS_W),
    .DEPTH (WINDOW_LEN)
  ) u_history (
    .clk   (clk),
    .we    (hist_we),
    .waddr (ptr),
    .wdata (pos_r),
    .raddr (ptr),
    .rdata (rdata)
  );

  epv_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (pop),
    .dividend  (head.quarter),
    .divisor   (cfg.counts_per_turn),
    .busy      (div_busy),
    .quotient  (quo),
    .remainder (rem)
  );

endmodule

@@ rtl/encoder_position_velocity.sv @@
// Encoder position and windowed velocity, top level with register file.
// The back takes a new item only after its 30-step quotient unit is through with the last one.
// Two count beats can be queued ahead of the back while it works.
// Reset (rst, synchronous): registers to defaults, queue empty, history reads as zero
// until the window has filled once; no clearing pass.
module encoder_position_velocity #(
  parameter int WINDOW_LEN = 8
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               count_valid,
  output logic                               count_stall,
  input  logic signed [epv_pkg::COUNT_W-1:0] encoder_count,
  output logic                               result_valid,
  input  logic                               result_stall,
  output logic signed [epv_pkg::POS_W-1:0]   position,
  output logic signed [epv_pkg::POS_W-1:0]   velocity,
  output logic signed [epv_pkg::TURN_W-1:0]  turn_index,
  output logic [epv_pkg::CPT_W-1:0]          count_in_turn,
  output logic [15:0]                        count_low,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [epv_pkg::ADDR_W-1:0]         paddr,
  input  logic [epv_pkg::DATA_W-1:0]         pwdata,
  output logic [epv_pkg::DATA_W-1:0]         prdata,
  output logic                               pready
);
  import epv_pkg::*;

  epv_cfg_t   cfg;
  epv_item_t  head;
  epv_stat_t  stat;
  logic       head_valid;
  logic       pop;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.position_scale  <= SCALE_RESET;
      cfg.inv_window_time <= IVT_RESET;
      cfg.counts_per_turn <= CPT_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        REG_POSITION_SCALE:  cfg.position_scale  <= pwdata;
        REG_INV_WINDOW_TIME: cfg.inv_window_time <= pwdata;
        REG_COUNTS_PER_TURN: cfg.counts_per_turn <= pwdata[CPT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_POSITION_SCALE:  prdata = cfg.position_scale;
      REG_INV_WINDOW_TIME: prdata = cfg.inv_window_time;
      REG_COUNTS_PER_TURN: prdata = {16'd0, cfg.counts_per_turn};
      default:             prdata = '0;
    endcase
  end

  epv_front u_front (
    .clk           (clk),
    .rst           (rst),
    .count_valid   (count_valid),
    .count_stall   (count_stall),
    .encoder_count (encoder_count),
    .head_valid    (head_valid),
    .head          (head),
    .pop           (pop)
  );

  epv_back #(
    .WINDOW_LEN (WINDOW_LEN)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .head_valid    (head_valid),
    .head          (head),
    .pop           (pop),
    .stat          (stat),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .position      (position),
    .velocity      (velocity),
    .turn_index    (turn_index),
    .count_in_turn (count_in_turn),
    .count_low     (count_low)
  );

  a_push_lands: assert property (@(posedge clk) disable iff (rst)
    (count_valid && !count_stall) |=> head_valid)
    else $error("accepted count beat did not reach the queue");

  a_pop_spacing: assert property (@(posedge clk) disable iff (rst)
    stat.pop |=> !stat.pop)
    else $error("back popped two items in a row");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(stat.busy))
    else $error("result beat raised while back was idle");

endmodule
